// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/sbpp_pkg.sv =====
// Package for the serial bootloader page programmer: types, codes, constants.
// No dependencies.
`default_nettype none
package sbpp_pkg;
   localparam int PageBytesDef  = 128;
   localparam int RxCapacityDef = 148;
   localparam int MaxPages      = 512;
   localparam int QDepth        = 4;

   localparam logic [7:0] OK_FIRST  = 8'd20;
   localparam logic [7:0] OK_SECOND = 8'd16;
   localparam logic [7:0] CH_SYNC   = 8'h30;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_U      = 8'h55;
   localparam logic [7:0] CH_D      = 8'h64;
   localparam logic [7:0] CH_F      = 8'h46;
   localparam logic [7:0] CH_T      = 8'h74;

   localparam logic [1:0] M_START = 2'd0;
   localparam logic [1:0] M_RX    = 2'd1;
   localparam logic [1:0] M_TICK  = 2'd2;
   localparam logic [1:0] M_FETCH = 2'd3;

   localparam logic [1:0] K_TX     = 2'd0;
   localparam logic [1:0] K_FETCH  = 2'd1;
   localparam logic [1:0] K_RESET  = 2'd2;
   localparam logic [1:0] K_STATUS = 2'd3;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_CONNECT   = 3'd1;
   localparam logic [2:0] PH_LOAD_PROG = 3'd2;
   localparam logic [2:0] PH_PROGRAM   = 3'd3;
   localparam logic [2:0] PH_LOAD_READ = 3'd4;
   localparam logic [2:0] PH_READ      = 3'd5;

   localparam logic [2:0] OC_NONE     = 3'd0;
   localparam logic [2:0] OC_DONE     = 3'd1;
   localparam logic [2:0] OC_MISMATCH = 3'd2;
   localparam logic [2:0] OC_TIMEOUT  = 3'd3;
   localparam logic [2:0] OC_REFUSED  = 3'd4;

   localparam logic [1:0] CSR_RETRY   = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_PAGES   = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic [8:0]  page_index;
      logic [2:0]  phase_now;
      logic [9:0]  pages_done;
      logic [2:0]  outcome;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/sbpp_front.sv =====
// Front end: accepts request beats and queues them for the sequencer.
// Depends on sbpp_pkg.
`default_nettype none
module sbpp_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire sbpp_pkg::req_type req_data,
   output logic                 q_valid,
   input  wire logic            q_pop,
   output sbpp_pkg::req_type    q_data
);
   import sbpp_pkg::*;
   localparam int AW = $clog2(QDepth);
   req_type       mem_ff [QDepth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push;

   assign req_ready = (cnt_ff != (AW+1)'(QDepth));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = q_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= req_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/sbpp_back.sv =====
// Back end: runs the programming sequence for one queued beat, then streams its
// result items one per cycle while rsp_ready is high. Depends on sbpp_pkg.
`default_nettype none
module sbpp_back #(
   parameter int PAGE_BYTES  = sbpp_pkg::PageBytesDef,
   parameter int RX_CAPACITY = sbpp_pkg::RxCapacityDef
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire sbpp_pkg::req_type q_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sbpp_pkg::rsp_type      rsp_data
);
   import sbpp_pkg::*;
   localparam int PW = $clog2(PAGE_BYTES);
   localparam int FW = $clog2(PAGE_BYTES + 1);
   localparam int RW = $clog2(RX_CAPACITY + 1);
   localparam logic [7:0] LEN_HI = 8'((PAGE_BYTES >> 8) & 255);
   localparam logic [7:0] LEN_LO = 8'(PAGE_BYTES & 255);

   // item under work
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic [8:0] page_index;
      logic [2:0] outcome;
   } item_type;

   logic [15:0] retry_ff, tmo_ff;
   logic [9:0]  pcount_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [9:0]  pctr_ff, pctr_in;
   logic [RW-1:0] rxc_ff, rxc_in;
   logic [7:0]  rxf_ff, rxf_in, rxs_ff, rxs_in, rxe_ff, rxe_in;
   logic        vm_ff, vm_in;
   logic [15:0] tc_ff, tc_in;
   logic        ta_ff, ta_in, tr_ff, tr_in;
   logic [FW-1:0] fc_ff, fc_in;
   logic [7:0]  store [PAGE_BYTES];
   logic [7:0]  rd_ff;

   // S_IDLE registers the page-store read, S_RD executes the beat, S_OUT streams
   localparam logic [1:0] S_IDLE = 2'd0, S_RD = 2'd1, S_OUT = 2'd2;
   logic [1:0] st_ff, st_in;
   item_type   it_ff [6], it_in [6];
   logic [2:0] n_ff, n_in, k_ff, k_in;
   logic       st_we;
   logic [PW-1:0] st_wa;
   logic [PW-1:0] rd_a;

   // read address for verify: rx position minus one
   assign rd_a = PW'(rxc_ff - RW'(1));

   always_ff @(posedge clock) begin
      if (st_we) store[st_wa] <= q_data.data_byte;
      rd_ff <= store[rd_a];
   end

   function automatic item_type mk(input logic [1:0] k, input logic [7:0] b,
                                   input logic [8:0] p, input logic [2:0] o);
      item_type r;
      r.kind = k; r.tx_byte = b; r.page_index = p; r.outcome = o;
      return r;
   endfunction

   logic [9:0] limit;
   logic       ok;
   logic [RW-1:0] p;
   logic [16:0] addr;
   logic [9:0]  pnext;

   always_comb begin
      phase_in = phase_ff; pctr_in = pctr_ff; rxc_in = rxc_ff;
      rxf_in = rxf_ff; rxs_in = rxs_ff; rxe_in = rxe_ff; vm_in = vm_ff;
      tc_in = tc_ff; ta_in = ta_ff; tr_in = tr_ff; fc_in = fc_ff;
      st_in = st_ff; n_in = n_ff; k_in = k_ff;
      for (int i = 0; i < 6; i++) it_in[i] = it_ff[i];
      q_pop = 1'b0; st_we = 1'b0; st_wa = fc_ff[PW-1:0];
      limit = (pcount_ff > 10'(MaxPages)) ? 10'(MaxPages) : pcount_ff;
      p = rxc_ff; ok = 1'b0; pnext = pctr_ff + 10'd1;
      addr = 17'(pctr_ff) * 17'(PAGE_BYTES);
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) st_in = S_RD;
         end
         S_RD: begin
            q_pop = 1'b1; n_in = '0; k_in = '0; st_in = S_OUT;
            unique case (q_data.mode)
               M_START: begin
                  if (phase_ff != PH_IDLE) begin
                     it_in[0] = mk(K_STATUS, 8'd0, 9'd0, OC_REFUSED); n_in = 3'd1;
                  end else begin
                     pctr_in = '0; rxc_in = '0; fc_in = '0; vm_in = 1'b0;
                     phase_in = PH_CONNECT;
                     it_in[0] = mk(K_RESET, 8'd0, 9'd0, OC_NONE);
                     it_in[1] = mk(K_TX, CH_SYNC, 9'd0, OC_NONE);
                     it_in[2] = mk(K_TX, CH_SP, 9'd0, OC_NONE);
                     n_in = 3'd3; tc_in = '0; ta_in = 1'b1; tr_in = 1'b1;
                  end
               end
               M_RX: if (phase_ff != PH_IDLE) begin
                  if (rxc_ff < RW'(RX_CAPACITY)) begin
                     if (p == RW'(0)) rxf_in = q_data.data_byte;
                     if (p == RW'(1)) rxs_in = q_data.data_byte;
                     if (phase_ff == PH_READ && p >= RW'(1) && p <= RW'(PAGE_BYTES)
                         && rd_ff != q_data.data_byte) vm_in = 1'b1;
                     if (p == RW'(PAGE_BYTES + 1)) rxe_in = q_data.data_byte;
                     rxc_in = p + RW'(1);
                  end
                  ok = rxc_in >= RW'(2) && rxf_in == OK_FIRST && rxs_in == OK_SECOND;
                  unique case (phase_ff)
                     PH_CONNECT, PH_PROGRAM: begin
                        if (ok && (phase_ff == PH_CONNECT || fc_ff >= FW'(PAGE_BYTES))) begin
                           phase_in = (phase_ff == PH_CONNECT) ? PH_LOAD_PROG : PH_LOAD_READ;
                           rxc_in = '0;
                           it_in[0] = mk(K_TX, CH_U, 9'd0, OC_NONE);
                           it_in[1] = mk(K_TX, addr[8:1], 9'd0, OC_NONE);
                           it_in[2] = mk(K_TX, addr[16:9], 9'd0, OC_NONE);
                           it_in[3] = mk(K_TX, CH_SP, 9'd0, OC_NONE);
                           n_in = 3'd4; tc_in = '0; ta_in = 1'b1; tr_in = 1'b0;
                        end
                     end
                     PH_LOAD_PROG: if (ok) begin
                        phase_in = PH_PROGRAM; rxc_in = '0; fc_in = '0;
                        it_in[0] = mk(K_FETCH, 8'd0, pctr_ff[8:0], OC_NONE);
                        it_in[1] = mk(K_TX, CH_D, 9'd0, OC_NONE);
                        it_in[2] = mk(K_TX, LEN_HI, 9'd0, OC_NONE);
                        it_in[3] = mk(K_TX, LEN_LO, 9'd0, OC_NONE);
                        it_in[4] = mk(K_TX, CH_F, 9'd0, OC_NONE);
                        n_in = 3'd5; tc_in = '0; ta_in = 1'b1; tr_in = 1'b0;
                     end
                     PH_LOAD_READ: if (ok) begin
                        phase_in = PH_READ; rxc_in = '0; vm_in = 1'b0;
                        it_in[0] = mk(K_TX, CH_T, 9'd0, OC_NONE);
                        it_in[1] = mk(K_TX, LEN_HI, 9'd0, OC_NONE);
                        it_in[2] = mk(K_TX, LEN_LO, 9'd0, OC_NONE);
                        it_in[3] = mk(K_TX, CH_F, 9'd0, OC_NONE);
                        it_in[4] = mk(K_TX, CH_SP, 9'd0, OC_NONE);
                        n_in = 3'd5; tc_in = '0; ta_in = 1'b1; tr_in = 1'b0;
                     end
                     PH_READ: begin
                        if (rxc_in >= RW'(PAGE_BYTES + 2) && rxf_in == OK_FIRST
                            && rxe_in == OK_SECOND) begin
                           if (vm_in) begin
                              phase_in = PH_IDLE; ta_in = 1'b0;
                              it_in[0] = mk(K_STATUS, 8'd0, 9'd0, OC_MISMATCH); n_in = 3'd1;
                           end else begin
                              pctr_in = pnext;
                              if (pnext >= limit) begin
                                 phase_in = PH_IDLE; ta_in = 1'b0;
                                 it_in[0] = mk(K_STATUS, 8'd0, 9'd0, OC_DONE); n_in = 3'd1;
                              end else begin
                                 phase_in = PH_LOAD_PROG; rxc_in = '0;
                                 addr = 17'(pnext) * 17'(PAGE_BYTES);
                                 it_in[0] = mk(K_TX, CH_U, 9'd0, OC_NONE);
                                 it_in[1] = mk(K_TX, addr[8:1], 9'd0, OC_NONE);
                                 it_in[2] = mk(K_TX, addr[16:9], 9'd0, OC_NONE);
                                 it_in[3] = mk(K_TX, CH_SP, 9'd0, OC_NONE);
                                 n_in = 3'd4; tc_in = '0; ta_in = 1'b1; tr_in = 1'b0;
                              end
                           end
                        end
                     end
                     default: ;
                  endcase
               end
               M_TICK: if (phase_ff != PH_IDLE && ta_ff) begin
                  tc_in = tc_ff + 16'd1;
                  if (tr_ff) begin
                     if (tc_in >= retry_ff) begin
                        if (phase_ff == PH_CONNECT) begin
                           it_in[0] = mk(K_TX, CH_SYNC, 9'd0, OC_NONE);
                           it_in[1] = mk(K_TX, CH_SP, 9'd0, OC_NONE);
                           n_in = 3'd2; tc_in = '0;
                        end else ta_in = 1'b0;
                     end
                  end else if (tc_in >= tmo_ff) begin
                     rxc_in = '0; phase_in = PH_IDLE; ta_in = 1'b0;
                     it_in[0] = mk(K_STATUS, 8'd0, 9'd0, OC_TIMEOUT); n_in = 3'd1;
                  end
               end
               M_FETCH: if (phase_ff == PH_PROGRAM && fc_ff < FW'(PAGE_BYTES)) begin
                  st_we = 1'b1; fc_in = fc_ff + FW'(1);
                  it_in[0] = mk(K_TX, q_data.data_byte, 9'd0, OC_NONE); n_in = 3'd1;
                  if (fc_in == FW'(PAGE_BYTES)) begin
                     it_in[1] = mk(K_TX, CH_SP, 9'd0, OC_NONE); n_in = 3'd2;
                     tc_in = '0; ta_in = 1'b1; tr_in = 1'b0;
                  end
               end
               default: ;
            endcase
            if (n_in == '0) st_in = S_IDLE;
         end
         S_OUT: begin
            if (rsp_ready) begin
               k_in = k_ff + 3'd1;
               if (k_in == n_ff) st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign rsp_valid = (st_ff == S_OUT);
   always_comb begin
      rsp_data.kind       = it_ff[k_ff].kind;
      rsp_data.tx_byte    = it_ff[k_ff].tx_byte;
      rsp_data.page_index = it_ff[k_ff].page_index;
      rsp_data.outcome    = it_ff[k_ff].outcome;
      rsp_data.phase_now  = phase_ff;
      rsp_data.pages_done = pctr_ff;
      rsp_data.last       = (k_ff + 3'd1 == n_ff);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) it_ff[i] <= it_in[i];
      if (reset) begin
         retry_ff <= 16'd300; tmo_ff <= 16'd500; pcount_ff <= 10'd256;
         phase_ff <= PH_IDLE; pctr_ff <= '0; rxc_ff <= '0; rxf_ff <= '0;
         rxs_ff <= '0; rxe_ff <= '0; vm_ff <= 1'b0; tc_ff <= '0; ta_ff <= 1'b0;
         tr_ff <= 1'b0; fc_ff <= '0; st_ff <= S_IDLE; n_ff <= '0; k_ff <= '0;
      end else begin
         phase_ff <= phase_in; pctr_ff <= pctr_in; rxc_ff <= rxc_in;
         rxf_ff <= rxf_in; rxs_ff <= rxs_in; rxe_ff <= rxe_in; vm_ff <= vm_in;
         tc_ff <= tc_in; ta_ff <= ta_in; tr_ff <= tr_in; fc_ff <= fc_in;
         st_ff <= st_in; n_ff <= n_in; k_ff <= k_in;
         if (csr_we) begin
            case (csr_index)
               CSR_RETRY:   retry_ff <= csr_wdata;
               CSR_TIMEOUT: tmo_ff <= csr_wdata;
               CSR_PAGES:   pcount_ff <= csr_wdata[9:0];
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/serial_bootloader_page_programmer_core.sv =====
// Serial bootloader page programmer, top level.
// A queued request beat passes through S_IDLE and S_RD before its first result beat,
// if it yields any, is valid in S_OUT; the sequencer takes no new beat until every result
// of the last one has been taken. The S_IDLE step gives the registered page-store read for
// verify its time. A 4-entry queue keeps req open. Reset (synchronous, active high) clears
// control state and the config registers to their defaults; the page store is not cleared.
`default_nettype none
`include "assert_macros.svh"
module serial_bootloader_page_programmer_core #(
   parameter int PAGE_BYTES  = sbpp_pkg::PageBytesDef,
   parameter int RX_CAPACITY = sbpp_pkg::RxCapacityDef
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sbpp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sbpp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);
   import sbpp_pkg::*;
   logic    q_valid, q_pop;
   req_type q_data;

   sbpp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_pop, .q_data
   );

   sbpp_back #(.PAGE_BYTES(PAGE_BYTES), .RX_CAPACITY(RX_CAPACITY)) u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .q_valid, .q_pop, .q_data, .rsp_valid, .rsp_ready, .rsp_data
   );

   `CHK_IMPL(a_pop_valid, clock, reset, q_pop, q_valid, "pop from empty queue")
   `CHK_IMPL(a_status_last, clock, reset, rsp_valid && rsp_data.kind == K_STATUS, rsp_data.last, "status not last")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
endmodule
`default_nettype wire
